// ===== rtl/ofsh_pkg.sv =====
`default_nettype none
package ofsh_pkg;

    // Fixed field widths
    localparam int SAMPLE_W   = 16;
    localparam int OFFSET_W   = 16;
    localparam int SENS_W     = 16;
    localparam int PREFIX_W   = 10;
    localparam int SYMLEN_W   = 13;
    localparam int PHASE_W    = 32;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Q0.16 x Q4.12 gives Q4.28, moved up to Q0.32 turns
    localparam int STEP_SHIFT = 4;

    localparam int MIN_SYMBOL_LENGTH = 2;

    // Rotator: Q2.30 vector, Q0.32 turn angle
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_W     = 32;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [PHASE_W-1:0] HALF_TURN    = 32'h8000_0000;

    // Mixer arithmetic
    localparam int PROD_W      = SAMPLE_W + CORDIC_W;
    localparam int SUM_W       = PROD_W + 1;
    localparam int ROUND_SHIFT = 30;
    localparam int ROUNDED_W   = SUM_W - ROUND_SHIFT;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (ROUND_SHIFT - 1);

    // Reset values of the registers
    localparam logic [SENS_W-1:0]   SENS_RESET   = 16'd256;
    localparam logic [PREFIX_W-1:0] PREFIX_RESET = 10'd0;
    localparam logic [SYMLEN_W-1:0] SYMLEN_RESET = 13'd64;

    typedef enum logic [1:0] {
        REG_SENS   = 2'd0,
        REG_PREFIX = 2'd1,
        REG_SYMLEN = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_re;
        logic signed [SAMPLE_W-1:0] sample_im;
        logic                       frame_start;
        logic signed [OFFSET_W-1:0] offset_estimate;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] shifted_re;
        logic signed [SAMPLE_W-1:0] shifted_im;
        logic                       symbol_end;
    } t_out_item;

    // Data handed from cell to cell along the rotator
    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [CORDIC_W-1:0] z;
        logic                       flip;
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
        logic                       symbol_end;
    } t_rot;

    // Arctangent of 2^-i in Q0.32 turns
    function automatic logic signed [CORDIC_W-1:0] atan_turns(input int idx);
        logic signed [CORDIC_W-1:0] v;
        case (idx)
            0:       v = 32'sd536870912;
            1:       v = 32'sd316933406;
            2:       v = 32'sd167458907;
            3:       v = 32'sd85004756;
            4:       v = 32'sd42667331;
            5:       v = 32'sd21354465;
            6:       v = 32'sd10679838;
            7:       v = 32'sd5340245;
            8:       v = 32'sd2670163;
            9:       v = 32'sd1335087;
            10:      v = 32'sd667544;
            11:      v = 32'sd333772;
            12:      v = 32'sd166886;
            13:      v = 32'sd83443;
            14:      v = 32'sd41722;
            15:      v = 32'sd20861;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Clamp a rounded mixer result to the sample range
    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [ROUNDED_W-1:0] v
    );
        logic signed [ROUNDED_W-1:0] hi;
        logic signed [ROUNDED_W-1:0] lo;
        logic signed [SAMPLE_W-1:0]  r;
        hi = ROUNDED_W'({1'b0, {(SAMPLE_W-1){1'b1}}});
        lo = -hi - ROUNDED_W'(1);
        if (v > hi) begin
            r = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else if (v < lo) begin
            r = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ofdm_symbol_frequency_shifter.sv =====
// The path holds 23 register stages in all, from the stage that accepts a
// transaction to the one that presents its result.
// Throughput: one transaction per cycle unless i_out_ready stalls the output;
// the phase accumulator stage takes one sample each cycle when not stalled and
// every other stage is a pipelined cell. Reset (i_rst_n low at a clock edge)
// empties the pipeline, sets the registers to sensitivity 256, prefix 0,
// symbol length 64, and clears phase, step and sample position.
`default_nettype none
module ofdm_symbol_frequency_shifter #(
    parameter int MAX_SYMBOL_LENGTH = 4096
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ofsh_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [ofsh_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [ofsh_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire ofsh_pkg::t_in_item              i_in_item,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output ofsh_pkg::t_out_item                  o_out_item
);
    import ofsh_pkg::*;

    localparam logic signed [CORDIC_W-1:0] Z_RESIDUAL_MAX = 32'sd65536;
    localparam logic signed [CORDIC_W-1:0] XY_MAG_MAX     = 32'sd1342177280;

    logic [SENS_W-1:0]   r_sens;
    logic [PREFIX_W-1:0] r_prefix;
    logic [SYMLEN_W-1:0] r_symlen;
    t_reg_idx            reg_idx;
    logic                cfg_write;

    t_rot                rot [0:CORDIC_STEPS];
    logic [CORDIC_STEPS:0] vld;
    logic [CORDIC_STEPS:0] rdy;

    // Register port
    assign pready    = 1'b1;
    assign reg_idx   = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens   <= SENS_RESET;
            r_prefix <= PREFIX_RESET;
            r_symlen <= SYMLEN_RESET;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_SENS:   r_sens   <= pwdata[SENS_W-1:0];
                REG_PREFIX: r_prefix <= pwdata[PREFIX_W-1:0];
                REG_SYMLEN: r_symlen <= pwdata[SYMLEN_W-1:0];
                default:    r_sens   <= r_sens;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SENS:   prdata = APB_DATA_W'(r_sens);
            REG_PREFIX: prdata = APB_DATA_W'(r_prefix);
            REG_SYMLEN: prdata = APB_DATA_W'(r_symlen);
            default:    prdata = '0;
        endcase
    end

    // Phase accumulator front end
    ofsh_phase #(
        .MAX_SYMBOL_LENGTH(MAX_SYMBOL_LENGTH)
    ) u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sens  (r_sens),
        .i_prefix(r_prefix),
        .i_symlen(r_symlen),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .o_valid (vld[0]),
        .i_ready (rdy[0]),
        .o_rot   (rot[0])
    );

    // Row of rotation cells
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        ofsh_cordic_cell #(
            .STEP(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(vld[g]),
            .o_ready(rdy[g]),
            .i_rot  (rot[g]),
            .o_valid(vld[g+1]),
            .i_ready(rdy[g+1]),
            .o_rot  (rot[g+1])
        );
    end

    // Complex multiply and output register
    ofsh_mix u_mix (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(vld[CORDIC_STEPS]),
        .o_ready(rdy[CORDIC_STEPS]),
        .i_rot  (rot[CORDIC_STEPS]),
        .o_valid(o_out_valid),
        .i_ready(i_out_ready),
        .o_item (o_out_item)
    );

    // A full row of cells facing a stalled mixer must stall its first cell
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&vld[CORDIC_STEPS:1] && !rdy[CORDIC_STEPS]) |-> !rdy[0])
        else $error("rotator row accepts data while full and stalled");

    // Residual angle after the last cell stays within +/-65536 in Q0.32 turns
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        vld[CORDIC_STEPS] |->
            (rot[CORDIC_STEPS].z <= Z_RESIDUAL_MAX) &&
            (rot[CORDIC_STEPS].z >= -Z_RESIDUAL_MAX))
        else $error("rotator residual angle too large");

    // Each component of the rotated vector stays within +/-1.25 in Q2.30
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        vld[CORDIC_STEPS] |->
            (rot[CORDIC_STEPS].x <= XY_MAG_MAX) && (rot[CORDIC_STEPS].x >= -XY_MAG_MAX) &&
            (rot[CORDIC_STEPS].y <= XY_MAG_MAX) && (rot[CORDIC_STEPS].y >= -XY_MAG_MAX))
        else $error("rotator vector out of range");

endmodule
`default_nettype wire

// ===== rtl/ofsh_phase.sv =====
`default_nettype none
module ofsh_phase #(
    parameter int MAX_SYMBOL_LENGTH = 4096
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [ofsh_pkg::SENS_W-1:0]   i_sens,
    input  wire logic [ofsh_pkg::PREFIX_W-1:0] i_prefix,
    input  wire logic [ofsh_pkg::SYMLEN_W-1:0] i_symlen,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire ofsh_pkg::t_in_item            i_item,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output ofsh_pkg::t_rot                     o_rot
);
    import ofsh_pkg::*;

    localparam int POS_W = (MAX_SYMBOL_LENGTH > 2) ? $clog2(MAX_SYMBOL_LENGTH) : 1;
    localparam int LEN_W = (POS_W + 1 > SYMLEN_W) ? POS_W + 1 : SYMLEN_W;
    localparam int MULA_W = SENS_W + 1 + OFFSET_W;
    localparam int MULB_W = PREFIX_W + 1 + PHASE_W;

    // Stage ready chain
    logic rdy_a, rdy_b, rdy_c, rdy_d;

    // Stage A: step product
    logic                       r_a_valid;
    logic signed [SAMPLE_W-1:0] r_a_re, r_a_im;
    logic                       r_a_frame;
    logic [PHASE_W-1:0]         r_a_step;
    logic signed [MULA_W-1:0]   mul_a;

    // Stage B: prefix skip product for a frame start
    logic                       r_b_valid;
    logic signed [SAMPLE_W-1:0] r_b_re, r_b_im;
    logic                       r_b_frame;
    logic [PHASE_W-1:0]         r_b_step;
    logic [PHASE_W-1:0]         r_b_fskip;
    logic [MULB_W-1:0]          mul_b;

    // Stage C: phase accumulator and position counter
    logic                       r_c_valid;
    logic [PHASE_W-1:0]         r_c_phase;
    logic signed [SAMPLE_W-1:0] r_c_re, r_c_im;
    logic                       r_c_end;
    logic [PHASE_W-1:0]         r_phase, r_step, r_skip, r_skipstep;
    logic [POS_W-1:0]           r_pos;
    logic [PHASE_W-1:0]         n_phase, n_step, phase_use;
    logic [POS_W-1:0]           n_pos, pos_cur;
    logic [LEN_W-1:0]           len_raw, len_clamp, pos_inc;
    logic                       last;
    logic [MULB_W-1:0]          mul_skip, mul_skipstep;

    // Stage D: fold into the rotator's range
    logic                       r_d_valid;
    t_rot                       r_d_rot;
    logic                       fold_flip;
    logic [PHASE_W-1:0]         fold_phase;

    assign rdy_d   = !r_d_valid || i_ready;
    assign rdy_c   = !r_c_valid || rdy_d;
    assign rdy_b   = !r_b_valid || rdy_c;
    assign rdy_a   = !r_a_valid || rdy_b;
    assign o_ready = rdy_a;
    assign o_valid = r_d_valid;
    assign o_rot   = r_d_rot;

    // Stage A
    assign mul_a = $signed({1'b0, i_sens}) * $signed(i_item.offset_estimate);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (rdy_a) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_valid) begin
            r_a_re    <= i_item.sample_re;
            r_a_im    <= i_item.sample_im;
            r_a_frame <= i_item.frame_start;
            r_a_step  <= {mul_a[PHASE_W-STEP_SHIFT-1:0], {STEP_SHIFT{1'b0}}};
        end
    end

    // Stage B
    assign mul_b = MULB_W'(i_prefix) * MULB_W'(r_a_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (rdy_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_b && r_a_valid) begin
            r_b_re    <= r_a_re;
            r_b_im    <= r_a_im;
            r_b_frame <= r_a_frame;
            r_b_step  <= r_a_step;
            r_b_fskip <= mul_b[PHASE_W-1:0];
        end
    end

    // Prefix skip for the running step, kept current every cycle
    assign mul_skip     = MULB_W'(i_prefix) * MULB_W'(r_step);
    assign mul_skipstep = (MULB_W'(i_prefix) + MULB_W'(1)) * MULB_W'(r_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip     <= '0;
            r_skipstep <= '0;
        end else begin
            r_skip     <= mul_skip[PHASE_W-1:0];
            r_skipstep <= mul_skipstep[PHASE_W-1:0];
        end
    end

    // Stage C: clamp length, pick phase, advance
    always_comb begin
        len_raw = LEN_W'(i_symlen);
        if (len_raw < LEN_W'(MIN_SYMBOL_LENGTH)) begin
            len_clamp = LEN_W'(MIN_SYMBOL_LENGTH);
        end else if (len_raw > LEN_W'(MAX_SYMBOL_LENGTH)) begin
            len_clamp = LEN_W'(MAX_SYMBOL_LENGTH);
        end else begin
            len_clamp = len_raw;
        end

        if (r_b_frame) begin
            pos_cur   = '0;
            n_step    = r_b_step;
            phase_use = r_b_fskip;
            n_phase   = r_b_fskip + r_b_step;
        end else if (r_pos == '0) begin
            pos_cur   = r_pos;
            n_step    = r_step;
            phase_use = r_phase + r_skip;
            n_phase   = r_phase + r_skipstep;
        end else begin
            pos_cur   = r_pos;
            n_step    = r_step;
            phase_use = r_phase;
            n_phase   = r_phase + r_step;
        end

        pos_inc = LEN_W'(pos_cur) + LEN_W'(1);
        last    = pos_inc >= len_clamp;
        n_pos   = last ? '0 : pos_inc[POS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_phase   <= '0;
            r_step    <= '0;
            r_pos     <= '0;
        end else begin
            if (rdy_c) begin
                r_c_valid <= r_b_valid;
            end
            if (rdy_c && r_b_valid) begin
                r_phase <= n_phase;
                r_step  <= n_step;
                r_pos   <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_c && r_b_valid) begin
            r_c_phase <= phase_use;
            r_c_re    <= r_b_re;
            r_c_im    <= r_b_im;
            r_c_end   <= last;
        end
    end

    // Stage D: flip by a half turn into [-1/4, 1/4)
    assign fold_flip  = (r_c_phase + QUARTER_TURN) >= HALF_TURN;
    assign fold_phase = fold_flip ? (r_c_phase - HALF_TURN) : r_c_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (rdy_d) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_d && r_c_valid) begin
            r_d_rot.x          <= CORDIC_GAIN;
            r_d_rot.y          <= '0;
            r_d_rot.z          <= $signed(fold_phase);
            r_d_rot.flip       <= fold_flip;
            r_d_rot.re         <= r_c_re;
            r_d_rot.im         <= r_c_im;
            r_d_rot.symbol_end <= r_c_end;
        end
    end

    // A frame start restarts the position count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rdy_c && r_b_valid && r_b_frame) |=> (r_pos <= POS_W'(1)))
        else $error("position not restarted on frame start");

endmodule
`default_nettype wire

// ===== rtl/ofsh_cordic_cell.sv =====
`default_nettype none
module ofsh_cordic_cell #(
    parameter int STEP = 0
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire ofsh_pkg::t_rot i_rot,
    output logic                o_valid,
    input  wire logic           i_ready,
    output ofsh_pkg::t_rot      o_rot
);
    import ofsh_pkg::*;

    logic                       r_valid;
    t_rot                       r_rot;
    logic signed [CORDIC_W-1:0] sx, sy;
    t_rot                       n_rot;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_rot   = r_rot;

    // One micro-rotation toward zero residual angle
    always_comb begin
        sx    = i_rot.x >>> STEP;
        sy    = i_rot.y >>> STEP;
        n_rot = i_rot;
        if (!i_rot.z[CORDIC_W-1]) begin
            n_rot.x = i_rot.x - sy;
            n_rot.y = i_rot.y + sx;
            n_rot.z = i_rot.z - atan_turns(STEP);
        end else begin
            n_rot.x = i_rot.x + sy;
            n_rot.y = i_rot.y - sx;
            n_rot.z = i_rot.z + atan_turns(STEP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rot <= n_rot;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ofsh_mix.sv =====
`default_nettype none
module ofsh_mix (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire ofsh_pkg::t_rot i_rot,
    output logic                o_valid,
    input  wire logic           i_ready,
    output ofsh_pkg::t_out_item o_item
);
    import ofsh_pkg::*;

    logic rdy_e, rdy_f, rdy_g;

    // Stage E: undo the half-turn flip
    logic                       r_e_valid;
    logic signed [CORDIC_W-1:0] r_e_c, r_e_s;
    logic signed [SAMPLE_W-1:0] r_e_re, r_e_im;
    logic                       r_e_end;

    // Stage F: partial products
    logic                       r_f_valid;
    logic signed [PROD_W-1:0]   r_f_rc, r_f_is, r_f_rs, r_f_ic;
    logic                       r_f_end;

    // Stage G: sum, round, saturate
    logic                       r_g_valid;
    t_out_item                  r_g_item;
    logic signed [SUM_W-1:0]    sum_re, sum_im;
    logic signed [ROUNDED_W-1:0] rnd_re, rnd_im;

    assign rdy_g   = !r_g_valid || i_ready;
    assign rdy_f   = !r_f_valid || rdy_g;
    assign rdy_e   = !r_e_valid || rdy_f;
    assign o_ready = rdy_e;
    assign o_valid = r_g_valid;
    assign o_item  = r_g_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
            r_g_valid <= 1'b0;
        end else begin
            if (rdy_e) begin
                r_e_valid <= i_valid;
            end
            if (rdy_f) begin
                r_f_valid <= r_e_valid;
            end
            if (rdy_g) begin
                r_g_valid <= r_f_valid;
            end
        end
    end

    // Stage E
    always_ff @(posedge i_clk) begin
        if (rdy_e && i_valid) begin
            r_e_c   <= i_rot.flip ? -i_rot.x : i_rot.x;
            r_e_s   <= i_rot.flip ? -i_rot.y : i_rot.y;
            r_e_re  <= i_rot.re;
            r_e_im  <= i_rot.im;
            r_e_end <= i_rot.symbol_end;
        end
    end

    // Stage F
    always_ff @(posedge i_clk) begin
        if (rdy_f && r_e_valid) begin
            r_f_rc  <= PROD_W'(r_e_re) * PROD_W'(r_e_c);
            r_f_is  <= PROD_W'(r_e_im) * PROD_W'(r_e_s);
            r_f_rs  <= PROD_W'(r_e_re) * PROD_W'(r_e_s);
            r_f_ic  <= PROD_W'(r_e_im) * PROD_W'(r_e_c);
            r_f_end <= r_e_end;
        end
    end

    // Stage G
    assign sum_re = SUM_W'(r_f_rc) - SUM_W'(r_f_is) + ROUND_HALF;
    assign sum_im = SUM_W'(r_f_rs) + SUM_W'(r_f_ic) + ROUND_HALF;
    assign rnd_re = ROUNDED_W'(sum_re >>> ROUND_SHIFT);
    assign rnd_im = ROUNDED_W'(sum_im >>> ROUND_SHIFT);

    always_ff @(posedge i_clk) begin
        if (rdy_g && r_f_valid) begin
            r_g_item.shifted_re <= sat_sample(rnd_re);
            r_g_item.shifted_im <= sat_sample(rnd_im);
            r_g_item.symbol_end <= r_f_end;
        end
    end

endmodule
`default_nettype wire
